// ----- rtl/alrk_pkg.sv -----
package alrk_pkg;

	typedef logic [31:0] word_t;

	typedef struct packed {
		word_t w0;
		word_t w1;
		word_t w2;
		word_t w3;
	} state_t;

	localparam logic [7:0] SBOX [256] = '{
		8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
		8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
		8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
		8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
		8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
		8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
		8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
		8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
		8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
		8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
		8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
		8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
		8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
		8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
		8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
		8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
	};

	function automatic logic [7:0] xtime(input logic [7:0] b);
		xtime = {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
	endfunction

	function automatic word_t bswap(input word_t w);
		bswap = {w[7:0], w[15:8], w[23:16], w[31:24]};
	endfunction

endpackage

// ----- rtl/alrk_cell.sv -----
module alrk_cell import alrk_pkg::*; #(
	parameter int RIDX = 0
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       vld_in,
	input  logic       var_in,
	input  logic [7:0] rc_in,
	input  state_t     st_in,
	output logic       vld_q,
	output logic       var_q,
	output logic [7:0] rc_q,
	output state_t     st_q
);
	localparam logic [7:0] RCON_V = SBOX[RIDX % 256];

	word_t w3, t;
	state_t nx;

	always_comb begin
		w3 = st_in.w3;
		if (!var_in) begin
			t = {SBOX[w3[23:16]], SBOX[w3[15:8]], SBOX[w3[7:0]], SBOX[w3[31:24]]}
				^ {rc_in, 24'h0};
		end else begin
			t = {SBOX[w3[20:13]], SBOX[w3[12:5]], SBOX[w3[7:0]], SBOX[w3[26:19]]}
				^ {4{RCON_V}};
		end
		nx.w0 = st_in.w0 ^ t;
		nx.w1 = st_in.w1 ^ nx.w0;
		nx.w2 = st_in.w2 ^ nx.w1;
		nx.w3 = st_in.w3 ^ nx.w2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else begin
			vld_q <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		var_q <= var_in;
		rc_q  <= xtime(rc_in);
		st_q  <= nx;
	end
endmodule

// ----- rtl/aes128_last_round_key_unit.sv -----
// AES-128 last round key unit.
// Request channel: drive seed_hi/lo and rand_hi/lo with start high; the
// request is taken at any clock edge where busy is low. busy is always low,
// so one request can be taken every cycle.
// Each request passes through a chain of ROUNDS round cells, one key
// expansion round per cell and one register per cell, plus one output
// register; throughput is one request per cycle.
// The result shows on key_hi/key_lo for exactly one cycle with done high.
// The receiver cannot stall; results are not held.
// cfg_valid/cfg_ready write the variant bit (cfg_data[0]); cfg_ready is
// always high. Write only while no request is in flight. The variant is
// sampled with each request and travels down the chain with it.
// Reset clears the variant to the standard schedule and empties the chain.
module aes128_last_round_key_unit import alrk_pkg::*; #(
	parameter int ROUNDS = 10
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [63:0] seed_hi,
	input  logic [63:0] seed_lo,
	input  logic [63:0] rand_hi,
	input  logic [63:0] rand_lo,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_data,
	output logic        done,
	output logic [63:0] key_hi,
	output logic [63:0] key_lo
);
	logic variant_q;
	logic [63:0] hi, lo;
	state_t st0;

	logic       vld [ROUNDS+1];
	logic       vr  [ROUNDS+1];
	logic [7:0] rc  [ROUNDS+1];
	state_t     st  [ROUNDS+1];

	assign busy = 1'b0;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			variant_q <= 1'b0;
		end else if (cfg_valid) begin
			variant_q <= cfg_data;
		end
	end

	always_comb begin
		hi = seed_hi ^ rand_hi;
		lo = seed_lo ^ rand_lo;
		if (!variant_q) begin
			st0 = '{w0: hi[63:32], w1: hi[31:0], w2: lo[63:32], w3: lo[31:0]};
		end else begin
			st0 = '{w0: hi[63:32], w1: hi[39:8], w2: {hi[7:0], lo[63:40]}, w3: lo[39:8]};
		end
	end

	assign vld[0] = start;
	assign vr[0]  = variant_q;
	assign rc[0]  = 8'h01;
	assign st[0]  = st0;

	for (genvar i = 0; i < ROUNDS; i++) begin : g_cell
		alrk_cell #(.RIDX(i)) u_cell (
			.clk(clk), .arst_n(arst_n),
			.vld_in(vld[i]), .var_in(vr[i]), .rc_in(rc[i]), .st_in(st[i]),
			.vld_q(vld[i+1]), .var_q(vr[i+1]), .rc_q(rc[i+1]), .st_q(st[i+1])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= vld[ROUNDS];
		end
	end

	always_ff @(posedge clk) begin
		key_hi <= {bswap(st[ROUNDS].w0), bswap(st[ROUNDS].w1)};
		key_lo <= {bswap(st[ROUNDS].w2), bswap(st[ROUNDS].w3)};
	end
endmodule

// ----- verif/tb_aes128_last_round_key_unit.sv -----
module tb_aes128_last_round_key_unit;
	import alrk_pkg::*;

	localparam int ROUNDS = 10;
	localparam int LATENCY = ROUNDS + 1;
	localparam int MAX_CYCLES = 400000;

	typedef struct {
		logic [63:0] hi;
		logic [63:0] lo;
	} round_key_t;

	class round_key_board;
		round_key_t pending[$];
		int errors;

		function void note_request(round_key_t k);
			pending.push_back(k);
		endfunction

		function void check_key(logic [63:0] hi, logic [63:0] lo);
			round_key_t k;
			if (pending.size() == 0) begin
				$display("%0t: unexpected key %h %h", $time, hi, lo);
				errors++;
				return;
			end
			k = pending.pop_front();
			if (k.hi !== hi) begin
				$display("%0t: key_hi expected %h actual %h", $time, k.hi, hi);
				errors++;
			end
			if (k.lo !== lo) begin
				$display("%0t: key_lo expected %h actual %h", $time, k.lo, lo);
				errors++;
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic start = 0;
	logic busy;
	logic [63:0] seed_hi = '0, seed_lo = '0, rand_hi = '0, rand_lo = '0;
	logic cfg_valid = 0;
	logic cfg_ready;
	logic cfg_data = 0;
	logic done;
	logic [63:0] key_hi, key_lo;

	round_key_board board;
	logic mode;
	int gap_pct;
	int cycles;

	aes128_last_round_key_unit #(.ROUNDS(ROUNDS)) u_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.seed_hi(seed_hi), .seed_lo(seed_lo), .rand_hi(rand_hi), .rand_lo(rand_lo),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.done(done), .key_hi(key_hi), .key_lo(key_lo)
	);

	always begin
		#6 clk = 1;
		#6 clk = 0;
	end

	function automatic logic [7:0] sb(logic [31:0] w, int sh);
		return SBOX[(w >> sh) & 32'hff];
	endfunction

	function automatic logic [31:0] byte_rev(logic [31:0] w);
		return {w[7:0], w[15:8], w[23:16], w[31:24]};
	endfunction

	function automatic round_key_t expand_last_key(logic v, logic [63:0] sh, logic [63:0] sl,
			logic [63:0] rh, logic [63:0] rl);
		logic [63:0] h, l;
		logic [31:0] w0, w1, w2, w3, t;
		logic [7:0] rc;
		round_key_t k;
		h = sh ^ rh;
		l = sl ^ rl;
		rc = 8'h01;
		if (!v) begin
			w0 = h[63:32]; w1 = h[31:0]; w2 = l[63:32]; w3 = l[31:0];
		end else begin
			w0 = h[63:32]; w1 = h[39:8]; w2 = {h[7:0], l[63:40]}; w3 = l[39:8];
		end
		for (int r = 0; r < ROUNDS; r++) begin
			if (!v) begin
				t = {sb(w3, 16) ^ rc, sb(w3, 8), sb(w3, 0), sb(w3, 24)};
				rc = {rc[6:0], 1'b0} ^ (rc[7] ? 8'h1b : 8'h00);
			end else begin
				t = {sb(w3, 13), sb(w3, 5), sb(w3, 0), sb(w3, 19)} ^ {4{SBOX[r]}};
			end
			w0 ^= t; w1 ^= w0; w2 ^= w1; w3 ^= w2;
		end
		k.hi = {byte_rev(w0), byte_rev(w1)};
		k.lo = {byte_rev(w2), byte_rev(w3)};
		return k;
	endfunction

	function automatic logic [63:0] rand64();
		logic [63:0] x;
		x = {$urandom(), $urandom()};
		case ($urandom_range(0, 7))
			0: x = '0;
			1: x = '1;
			default: ;
		endcase
		return x;
	endfunction

	task automatic send_request(logic [63:0] sh, logic [63:0] sl, logic [63:0] rh,
			logic [63:0] rl);
		while ($urandom_range(0, 99) < gap_pct) begin
			start <= 0;
			@(posedge clk);
		end
		start <= 1;
		seed_hi <= sh; seed_lo <= sl; rand_hi <= rh; rand_lo <= rl;
		@(posedge clk);
		while (busy) @(posedge clk);
		board.note_request(expand_last_key(mode, sh, sl, rh, rl));
	endtask

	task automatic drain();
		start <= 0;
		@(posedge clk);
		while (board.pending.size() != 0) @(posedge clk);
		repeat (LATENCY + 2) @(posedge clk);
	endtask

	task automatic write_variant(logic v);
		cfg_valid <= 1;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 0;
		mode = v;
	endtask

	always @(posedge clk) begin
		if (arst_n && done) board.check_key(key_hi, key_lo);
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > MAX_CYCLES) begin
			$display("Verification failed");
			$finish;
		end
	end

	initial begin
		int gaps[4] = '{0, 71, 0, 16};
		board = new();
		mode = 0;
		gap_pct = 0;
		cycles = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed, reset variant
		send_request('0, '0, '0, '0);
		send_request('1, '1, '0, '0);
		send_request('1, '0, '0, '1);
		send_request(64'h2b7e151628aed2a6, 64'habf7158809cf4f3c, '0, '0);
		send_request(64'h8000000000000000, '0, '0, 64'h1);
		send_request('0, 64'hff, 64'h1, '0);
		drain();
		write_variant(1);
		send_request('0, '0, '0, '0);
		send_request('1, '1, '0, '0);
		send_request('0, 64'hff, '0, '0);
		send_request(64'hff, '0, '0, 64'hff00000000000000);
		send_request(64'h0123456789abcdef, 64'hfedcba9876543210, '1, '0);
		drain();

		for (int ph = 0; ph < 8; ph++) begin
			write_variant(ph[0]);
			gap_pct = gaps[ph % 4];
			repeat (175) send_request(rand64(), rand64(), rand64(), rand64());
			drain();
		end

		if (board.errors == 0 && board.pending.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end
endmodule
